FILE: design/bdss_pkg.sv
// Shared types and constants for the brake/direction/speed sequencer.
// No dependencies; imported by bdss_step and the top level.
`default_nettype none

package bdss_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ACCEL  = 3'd1,
    MODE_DECEL  = 3'd2,
    MODE_TO_POS = 3'd3,
    MODE_TO_NEG = 3'd4
  } mode_t;

  // Control levels that travel together between the step logic and the top level.
  typedef struct packed {
    mode_t mode;
    logic  brake;
    logic  dir;
  } ctl_t;

  localparam logic [7:0] DEADBAND_RESET = 8'd20;
  localparam int unsigned MODE_BITS = 3;

endpackage

`default_nettype wire

FILE: design/bdss_step.sv
// Next-state logic for one speed sample of the sequencer.
// Pure combinational; depends on bdss_pkg.
`default_nettype none

module bdss_step
  import bdss_pkg::*;
#(
  parameter int SPEED_BITS = 13
) (
  input  wire ctl_t                   ctl_cur,
  input  wire logic signed [SPEED_BITS-1:0] held_cur,
  input  wire logic [SPEED_BITS-1:0]  pwm_cur,
  input  wire logic [7:0]             deadband,
  input  wire logic signed [SPEED_BITS-1:0] real_spd,
  input  wire logic                   cmd_valid,
  input  wire logic signed [SPEED_BITS-1:0] cmd_spd,
  output ctl_t                        ctl_nxt,
  output logic signed [SPEED_BITS-1:0] held_nxt,
  output logic [SPEED_BITS-1:0]       pwm_nxt
);

  logic signed [SPEED_BITS:0] diff;
  logic [SPEED_BITS:0]        diff_mag;
  logic [SPEED_BITS:0]        real_mag;
  logic [SPEED_BITS:0]        db_ext;
  logic signed [SPEED_BITS-1:0] tgt;
  logic [SPEED_BITS-1:0]      tgt_mag;
  logic                       settled;
  logic                       near_zero;
  logic                       same_sign_held;
  logic                       same_sign_cmd;
  logic                       idle_like;

  assign db_ext = {{(SPEED_BITS-7){1'b0}}, deadband};

  assign diff = {real_spd[SPEED_BITS-1], real_spd} - {held_cur[SPEED_BITS-1], held_cur};
  assign diff_mag = diff[SPEED_BITS] ? (~diff + 1'b1) : diff;
  assign real_mag = real_spd[SPEED_BITS-1] ?
                    (~{1'b1, real_spd} + 1'b1) : {1'b0, real_spd};

  assign settled   = (diff_mag <= db_ext);
  assign near_zero = (real_mag < db_ext);

  // Target speed is the new command in idle, otherwise the held one.
  assign idle_like = (ctl_cur.mode != MODE_ACCEL) && (ctl_cur.mode != MODE_DECEL) &&
                     (ctl_cur.mode != MODE_TO_POS) && (ctl_cur.mode != MODE_TO_NEG);
  assign tgt     = idle_like ? cmd_spd : held_cur;
  assign tgt_mag = tgt[SPEED_BITS-1] ? (~tgt + 1'b1) : tgt;

  assign same_sign_held = (held_cur[SPEED_BITS-1] == real_spd[SPEED_BITS-1]);
  assign same_sign_cmd  = (cmd_spd[SPEED_BITS-1] == real_spd[SPEED_BITS-1]);

  always_comb begin
    ctl_nxt  = ctl_cur;
    held_nxt = held_cur;
    pwm_nxt  = pwm_cur;
    unique case (ctl_cur.mode)
      MODE_ACCEL: begin
        if (settled) begin
          ctl_nxt.mode = MODE_IDLE;
        end
      end
      MODE_DECEL: begin
        if (same_sign_held) begin
          if (settled) begin
            ctl_nxt.brake = 1'b0;
            pwm_nxt       = tgt_mag;
            ctl_nxt.mode  = MODE_IDLE;
          end
        end else if (near_zero) begin
          ctl_nxt.mode = ctl_cur.dir ? MODE_TO_POS : MODE_TO_NEG;
        end
      end
      MODE_TO_POS, MODE_TO_NEG: begin
        ctl_nxt.dir   = (ctl_cur.mode == MODE_TO_NEG);
        ctl_nxt.brake = 1'b0;
        pwm_nxt       = tgt_mag;
        ctl_nxt.mode  = MODE_ACCEL;
      end
      default: begin
        ctl_nxt.mode = MODE_IDLE;
        if (cmd_valid) begin
          held_nxt = cmd_spd;
          if (cmd_spd > real_spd) begin
            if (same_sign_cmd && !ctl_cur.dir) begin
              pwm_nxt      = tgt_mag;
              ctl_nxt.mode = MODE_ACCEL;
            end else begin
              pwm_nxt       = '0;
              ctl_nxt.brake = 1'b1;
              ctl_nxt.mode  = MODE_DECEL;
            end
          end else if (cmd_spd < real_spd) begin
            if (same_sign_cmd && ctl_cur.dir) begin
              pwm_nxt      = tgt_mag;
              ctl_nxt.mode = MODE_ACCEL;
            end else begin
              pwm_nxt       = '0;
              ctl_nxt.brake = 1'b1;
              ctl_nxt.mode  = MODE_DECEL;
            end
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/brake_direction_speed_sequencer.sv
// Top level of the brake/direction/speed sequencer: input register, state registers, ports.
// Depends on bdss_pkg and bdss_step.
`default_nettype none

// Each input transaction carries one measured speed sample (signed rpm) and, flagged by
// in_tuser, an optional new speed command. The sequencer walks through idle, accelerate,
// brake-decelerate and two one-step direction reversals, and after every sample emits
// one output transaction with the PWM magnitude, brake level, direction level and mode
// as they stand after that sample. A command is taken only in idle; zero counts as
// positive. Throughput is one transaction per clock unless the result stream stalls.
// The input register loads at the accepting edge; the state registers, which also serve
// as the output register, load when that sample fires, which a result stall can delay.
// The loop that bounds the rate is the state update through bdss_step. cfg_wr_en
// writes the deadband (reset 20 rpm); write it only while no transaction is in flight.
module brake_direction_speed_sequencer
  import bdss_pkg::*;
#(
  parameter int SPEED_BITS = 13
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // Input stream
  input  wire logic in_tvalid,
  output logic      in_tready,
  // [SPEED_BITS-1:0] measured_speed, [2*SPEED_BITS-1:SPEED_BITS] command_speed, zero pad
  input  wire logic [((2*SPEED_BITS+7)/8)*8-1:0] in_tdata,
  // [0] command_valid
  input  wire logic in_tuser,
  // Result stream
  output logic      out_tvalid,
  input  wire logic out_tready,
  // [SPEED_BITS-1:0] pwm_magnitude, [+0] brake_on, [+1] reverse_dir, [+4:+2] mode, zero pad
  output logic [((SPEED_BITS+5+7)/8)*8-1:0] out_tdata,
  // Configuration
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  localparam int OUT_DW = ((SPEED_BITS+5+7)/8)*8;

  // Input register
  logic                         in_valid_r;
  logic signed [SPEED_BITS-1:0] real_r;
  logic signed [SPEED_BITS-1:0] cmd_r;
  logic                         cmd_valid_r;

  // Sequencer state; doubles as the result register
  ctl_t                         ctl_r, ctl_nxt;
  logic signed [SPEED_BITS-1:0] held_r, held_nxt;
  logic [SPEED_BITS-1:0]        pwm_r, pwm_nxt;
  logic                         out_valid_r;
  logic [7:0]                   deadband_r;

  logic advance;
  logic fire;

  // Advance when the result slot is empty or being drained this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Payload: capture on every accepted transaction, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      real_r      <= in_tdata[SPEED_BITS-1:0];
      cmd_r       <= in_tdata[2*SPEED_BITS-1:SPEED_BITS];
      cmd_valid_r <= in_tuser;
    end
  end

  bdss_step #(
    .SPEED_BITS (SPEED_BITS)
  ) u_step (
    .ctl_cur   (ctl_r),
    .held_cur  (held_r),
    .pwm_cur   (pwm_r),
    .deadband  (deadband_r),
    .real_spd  (real_r),
    .cmd_valid (cmd_valid_r),
    .cmd_spd   (cmd_r),
    .ctl_nxt   (ctl_nxt),
    .held_nxt  (held_nxt),
    .pwm_nxt   (pwm_nxt)
  );

  // Update state and present the result in the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '{mode: MODE_IDLE, brake: 1'b0, dir: 1'b0};
      held_r      <= '0;
      pwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      ctl_r       <= ctl_nxt;
      held_r      <= held_nxt;
      pwm_r       <= pwm_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RESET;
    end else if (cfg_wr_en) begin
      deadband_r <= cfg_wr_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-SPEED_BITS-2-MODE_BITS){1'b0}},
                       ctl_r.mode, ctl_r.dir, ctl_r.brake, pwm_r};

  // The brake is only ever applied with the PWM magnitude at zero.
  a_brake_no_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.brake |-> (pwm_r == '0))
    else $error("brake applied with nonzero pwm");

  // Decelerating always holds the brake.
  a_decel_brake: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.mode == MODE_DECEL) |-> ctl_r.brake)
    else $error("decel without brake");

  // A reversal step always hands over to accelerate on the next processed sample.
  a_reverse_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ((ctl_r.mode == MODE_TO_POS) || (ctl_r.mode == MODE_TO_NEG)))
      |=> (ctl_r.mode == MODE_ACCEL) && !ctl_r.brake)
    else $error("reversal did not advance to accelerate");

  // A pending result is never overwritten while stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !fire)
    else $error("result overwritten under stall");

endmodule

`default_nettype wire

FILE: tb/bdss_drive_checker.sv
// Checker for the brake/direction/speed sequencer: mirrors the control state, predicts the
// drive levels for each sample and compares them with the result stream.
// Depends on bdss_pkg (mode_t, DEADBAND_RESET).
module bdss_drive_checker
  import bdss_pkg::*;
#(
  parameter int SPEED_BITS = 13,
  parameter int IN_BITS    = ((2*SPEED_BITS+7)/8)*8,
  parameter int OUT_BITS   = ((SPEED_BITS+5+7)/8)*8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [IN_BITS-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OUT_BITS-1:0] out_tdata,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  output int                  mismatch_count,
  output int                  pending_count,
  output int                  results_checked,
  output logic [4:0]          modes_seen
);

  typedef struct {
    logic [SPEED_BITS-1:0] pwm;
    logic                  brake;
    logic                  dir;
    logic [2:0]            mode;
  } drive_levels_t;

  // Mirrored control state.
  mode_t                 drive_mode;
  int                    held_rpm;
  logic                  dir_level;
  logic                  brake_level;
  logic [SPEED_BITS-1:0] pwm_level;
  int                    deadband;

  drive_levels_t expected_drive[$];

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic start_accel();
    pwm_level  = SPEED_BITS'(magnitude(held_rpm));
    drive_mode = MODE_ACCEL;
  endtask

  task automatic start_brake();
    pwm_level   = '0;
    brake_level = 1'b1;
    drive_mode  = MODE_DECEL;
  endtask

  // Advance the mirrored state by one sample and return the levels it leaves behind.
  task automatic advance_drive_levels(input int speed, input logic has_cmd, input int cmd,
                                      output drive_levels_t levels);
    logic same_sign;
    case (drive_mode)
      MODE_ACCEL: begin
        if (magnitude(speed - held_rpm) <= deadband) drive_mode = MODE_IDLE;
      end
      MODE_DECEL: begin
        if ((held_rpm >= 0) == (speed >= 0)) begin
          if (magnitude(speed - held_rpm) <= deadband) begin
            brake_level = 1'b0;
            pwm_level   = SPEED_BITS'(magnitude(held_rpm));
            drive_mode  = MODE_IDLE;
          end
        end else if (magnitude(speed) < deadband) begin
          drive_mode = dir_level ? MODE_TO_POS : MODE_TO_NEG;
        end
      end
      MODE_TO_POS, MODE_TO_NEG: begin
        dir_level   = (drive_mode == MODE_TO_NEG);
        brake_level = 1'b0;
        start_accel();
      end
      default: begin
        drive_mode = MODE_IDLE;
        if (has_cmd) begin
          held_rpm  = cmd;
          same_sign = (held_rpm >= 0) == (speed >= 0);
          if (held_rpm > speed) begin
            if (same_sign && !dir_level) start_accel();
            else start_brake();
          end else if (held_rpm < speed) begin
            if (same_sign && dir_level) start_accel();
            else start_brake();
          end
        end
      end
    endcase
    levels.pwm   = pwm_level;
    levels.brake = brake_level;
    levels.dir   = dir_level;
    levels.mode  = drive_mode;
  endtask

  always @(posedge clk) begin : watch_channels
    drive_levels_t want;
    drive_levels_t got;
    if (!rst_n) begin
      drive_mode      = MODE_IDLE;
      held_rpm        = 0;
      dir_level       = 1'b0;
      brake_level     = 1'b0;
      pwm_level       = '0;
      deadband        = DEADBAND_RESET;
      mismatch_count  = 0;
      results_checked = 0;
      modes_seen      = '0;
      expected_drive.delete();
      pending_count  <= 0;
    end else begin
      if (cfg_wr_en) deadband = cfg_wr_data;

      // Retire the oldest expectation before queuing a new one.
      if (out_tvalid && out_tready) begin
        got.pwm   = out_tdata[SPEED_BITS-1:0];
        got.brake = out_tdata[SPEED_BITS];
        got.dir   = out_tdata[SPEED_BITS+1];
        got.mode  = out_tdata[SPEED_BITS+4:SPEED_BITS+2];
        results_checked++;
        if (got.mode <= MODE_TO_NEG) modes_seen[got.mode] = 1'b1;
        if (expected_drive.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result pwm=%0d brake=%0b dir=%0b mode=%0d",
                     $time, got.pwm, got.brake, got.dir, got.mode);
        end else begin
          want = expected_drive.pop_front();
          if (got.pwm !== want.pwm || got.brake !== want.brake ||
              got.dir !== want.dir || got.mode !== want.mode) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected pwm=%0d brake=%0b dir=%0b mode=%0d, got pwm=%0d brake=%0b dir=%0b mode=%0d",
                       $time, want.pwm, want.brake, want.dir, want.mode,
                       got.pwm, got.brake, got.dir, got.mode);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        advance_drive_levels(int'($signed(in_tdata[SPEED_BITS-1:0])), in_tuser,
                             int'($signed(in_tdata[2*SPEED_BITS-1:SPEED_BITS])), want);
        expected_drive.push_back(want);
      end
      pending_count <= expected_drive.size();
    end
  end

endmodule

FILE: tb/brake_direction_speed_sequencer_test.sv
// Testbench top for the brake/direction/speed sequencer: clock, reset, stimulus, back
// pressure and verdict. Depends on bdss_pkg, the sequencer RTL and bdss_drive_checker.
module brake_direction_speed_sequencer_test;
  import bdss_pkg::*;

  localparam int SB        = 13;
  localparam int IN_BITS   = ((2*SB+7)/8)*8;
  localparam int OUT_BITS  = ((SB+5+7)/8)*8;
  localparam int SPEED_MAX = 2**(SB-1) - 1;
  localparam int SPEED_MIN = -(2**(SB-1));
  // Items per deadband phase of the random part.
  localparam int PHASE_ITEMS   = 170;
  // Cycles the receiver holds off once, to fill the block and stall its input.
  localparam int RECEIVER_HOLD = 150;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // [12:0] measured_speed, [25:13] command_speed, [31:26] zero
  logic [IN_BITS-1:0]  in_tdata = '0;
  // [0] command_valid
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [12:0] pwm_magnitude, [13] brake_on, [14] reverse_dir, [17:15] mode, [23:18] zero
  logic [OUT_BITS-1:0] out_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [7:0]          cfg_wr_data = '0;

  int         mismatch_count;
  int         pending_count;
  int         results_checked;
  logic [4:0] modes_seen;

  int items_sent = 0;
  int commands_sent = 0;
  bit steady_sender = 1'b0;
  bit stall_request = 1'b0;
  bit stall_done = 1'b0;

  // Simulated motor that follows the last command, so that the block sees plausible
  // speed traces and walks through settling, braking and reversal.
  int motor_rpm = 0;
  int motor_goal = 0;

  brake_direction_speed_sequencer #(.SPEED_BITS(SB)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bdss_drive_checker #(.SPEED_BITS(SB)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .modes_seen      (modes_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int clamp_speed(input int v);
    if (v > SPEED_MAX) return SPEED_MAX;
    if (v < SPEED_MIN) return SPEED_MIN;
    return v;
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Offer one sample after a random gap and hold it until the block takes the transaction.
  // Called right after a rising edge; returns at the edge of acceptance.
  task automatic offer_sample(input int meas, input bit has_cmd, input int cmd);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (steady_sender || pick < 60) gap = 0;
    else if (pick < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_BITS'({cmd[SB-1:0], meas[SB-1:0]});
    in_tuser  <= has_cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (has_cmd) commands_sent++;
  endtask

  // Drop valid and wait for every outstanding result, then let the pipeline empty.
  task automatic drain_results(input int limit);
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    // Wait for a further edge before checking, so the count includes the transaction accepted at the last edge.
    @(posedge clk);
    while (pending_count != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Receiver: ready runs, short and occasional long stalls, and one long hold-off on request.
  initial begin : result_ready_gen
    int run;
    int pick;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        out_tready <= 1'b0;
        repeat (RECEIVER_HOLD) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_tready <= 1'b1;
          run = $urandom_range(1, 40);
        end else if (pick < 94) begin
          out_tready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          run = $urandom_range(8, 40);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    // Directed samples: measured speed, command flag, command speed.
    int dir_meas [25] = '{0, 0, 0, 500, 990, 1000, 4095, 4095, 2000, 19,
                          -4096, -4096, -4096, -110, -100, -3000, -3000, -20, -19, 4095,
                          0, -1, 0, 100, -4096};
    bit dir_has  [25] = '{0, 1, 1, 1, 0, 1, 0, 1, 0, 0,
                          0, 0, 1, 0, 1, 0, 1, 0, 0, 1,
                          0, 1, 0, 1, 1};
    int dir_cmd  [25] = '{0, 0, 1000, -4096, 0, 4095, 0, -4096, 0, 0,
                          0, 0, -100, 0, -3000, 0, 0, 0, 0, -4096,
                          0, 0, 0, 100, 4095};
    logic [7:0] deadband_plan [5];
    bit  give;
    int  goal_gap;
    int  cap;
    int  step;

    deadband_plan[0] = 8'd255;
    deadband_plan[1] = 8'd0;
    deadband_plan[2] = 8'd1;
    deadband_plan[3] = 8'($urandom_range(2, 254));
    deadband_plan[4] = DEADBAND_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset deadband: equal command stays idle, a command outside
    // idle is ignored, reversal both ways, settling within the band, zero counted as
    // positive, and the field extremes.
    for (int i = 0; i < 25; i++) offer_sample(dir_meas[i], dir_has[i], dir_cmd[i]);

    for (int phase = 0; phase < 5; phase++) begin
      drain_results(2000);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= deadband_plan[phase];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      // Hold off the receiver once while the sender keeps offering.
      if (phase == 1) stall_request = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) steady_sender = !steady_sender;
        if ($urandom_range(0, 4) == 0) begin
          // Noise: any pattern on every field.
          offer_sample(int'($urandom), $urandom_range(0, 1), int'($urandom));
        end else begin
          give = ($urandom_range(0, 11) == 0);
          if (give) begin
            case ($urandom_range(0, 5))
              0: motor_goal = motor_rpm;
              1: motor_goal = clamp_speed(-motor_rpm);
              2: motor_goal = $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
              default: motor_goal = int'($urandom_range(0, 3000)) - 1500;
            endcase
          end
          offer_sample(motor_rpm, give, motor_goal);
          // Advance the motor toward its goal, slowing near zero so reversals can trigger.
          goal_gap = motor_goal - motor_rpm;
          cap = magnitude(motor_rpm) / 2;
          if (cap < 4) cap = 4;
          if (cap > 300) cap = 300;
          step = $urandom_range(1, cap);
          if (step > magnitude(goal_gap)) step = magnitude(goal_gap);
          motor_rpm += (goal_gap < 0) ? -step : step;
          if ($urandom_range(0, 9) == 0) motor_rpm += int'($urandom_range(0, 6)) - 3;
          motor_rpm = clamp_speed(motor_rpm);
        end
      end
    end

    drain_results(2000);
    repeat (8) @(posedge clk);

    $display("Sent %0d samples (%0d with commands) over 6 deadband settings;",
             items_sent, commands_sent);
    $display("%0d results compared; modes seen in results, idle in bit 0: %b",
             results_checked, modes_seen);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
